// ===== src/rhs_pkg.sv =====
// Shared types and constants for the RGB to hue/saturation unit.
`default_nettype none
package rhs_pkg;

   localparam int ChanW    = 8;
   localparam int QuotW    = 8;
   localparam int HueRemW  = 19;
   localparam int HueDivW  = 18;
   localparam int SatRemW  = 16;
   localparam int SatDivW  = 15;
   localparam int NumW     = 11;

   localparam logic [HueDivW-1:0] HUE_GREY_DIV = HueDivW'(768);
   localparam logic [SatDivW-1:0] SAT_GREY_DIV = SatDivW'(128);

   typedef struct packed {
      logic [HueRemW-1:0] hue_rem;
      logic [HueDivW-1:0] hue_div;
      logic [QuotW-1:0]   hue_quot;
      logic [SatRemW-1:0] sat_rem;
      logic [SatDivW-1:0] sat_div;
      logic [QuotW-1:0]   sat_quot;
   } div_word_type;

endpackage
`default_nettype wire

// ===== src/rhs_req_if.sv =====
// Input channel carrying one RGB pixel per word.
`default_nettype none
interface rhs_req_if;
   logic                      valid;
   logic                      ready;
   logic [rhs_pkg::ChanW-1:0] red;
   logic [rhs_pkg::ChanW-1:0] green;
   logic [rhs_pkg::ChanW-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== src/rhs_rsp_if.sv =====
// Result channel carrying hue and saturation per word.
`default_nettype none
interface rhs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rhs_pkg::QuotW-1:0] hue;
   logic [rhs_pkg::QuotW-1:0] saturation;

   modport source (output valid, output hue, output saturation, input ready);
   modport sink   (input valid, input hue, input saturation, output ready);
endinterface
`default_nettype wire

// ===== src/rhs_prep.sv =====
// Front stage: channel max/min, hue numerator and divisor setup.
`default_nettype none
module rhs_prep (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [rhs_pkg::ChanW-1:0] red,
   input  wire logic [rhs_pkg::ChanW-1:0] green,
   input  wire logic [rhs_pkg::ChanW-1:0] blue,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output rhs_pkg::div_word_type          out_word
);

   logic                         valid_ff;
   rhs_pkg::div_word_type        word_ff;
   rhs_pkg::div_word_type        word_in;
   logic [rhs_pkg::ChanW-1:0]    mx;
   logic [rhs_pkg::ChanW-1:0]    mn;
   logic [rhs_pkg::ChanW-1:0]    d;
   logic [rhs_pkg::NumW-1:0]     d6;
   logic [rhs_pkg::NumW-1:0]     num;
   logic [rhs_pkg::HueRemW-1:0]  num_x;
   logic [rhs_pkg::SatRemW-1:0]  d_x;
   logic                         grey;

   always_comb begin
      mx = (red > green) ? red : green;
      if (blue > mx) begin
         mx = blue;
      end
      mn = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      d    = mx - mn;
      grey = (d == '0);
      d6   = (rhs_pkg::NumW'(d) << 2) + (rhs_pkg::NumW'(d) << 1);
      if (mx == red) begin
         if (green >= blue) begin
            num = rhs_pkg::NumW'(green) - rhs_pkg::NumW'(blue);
         end else begin
            num = d6 - (rhs_pkg::NumW'(blue) - rhs_pkg::NumW'(green));
         end
      end else if (mx == green) begin
         num = rhs_pkg::NumW'(blue) + (rhs_pkg::NumW'(d) << 1) - rhs_pkg::NumW'(red);
      end else begin
         num = rhs_pkg::NumW'(red) + (rhs_pkg::NumW'(d) << 2) - rhs_pkg::NumW'(green);
      end
      num_x = rhs_pkg::HueRemW'(num);
      d_x   = rhs_pkg::SatRemW'(d);

      word_in.hue_quot = '0;
      word_in.sat_quot = '0;
      if (grey) begin
         word_in.hue_rem = '0;
         word_in.sat_rem = '0;
         word_in.hue_div = rhs_pkg::HUE_GREY_DIV;
         word_in.sat_div = rhs_pkg::SAT_GREY_DIV;
      end else begin
         word_in.hue_rem = (num_x << 8) - (num_x << 1);
         word_in.sat_rem = (d_x << 8) - (d_x << 1);
         word_in.hue_div = rhs_pkg::HueDivW'(d6) << (rhs_pkg::QuotW - 1);
         word_in.sat_div = rhs_pkg::SatDivW'(mx) << (rhs_pkg::QuotW - 1);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/rhs_div_cell.sv =====
// One restoring-division cell: one quotient bit for hue and saturation.
`default_nettype none
module rhs_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rhs_pkg::div_word_type in_word,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rhs_pkg::div_word_type      out_word
);

   logic                  valid_ff;
   rhs_pkg::div_word_type word_ff;
   rhs_pkg::div_word_type word_in;
   logic                  hue_take;
   logic                  sat_take;

   always_comb begin
      hue_take = in_word.hue_rem >= rhs_pkg::HueRemW'(in_word.hue_div);
      sat_take = in_word.sat_rem >= rhs_pkg::SatRemW'(in_word.sat_div);
      word_in.hue_rem  = hue_take ? in_word.hue_rem - rhs_pkg::HueRemW'(in_word.hue_div)
                                  : in_word.hue_rem;
      word_in.sat_rem  = sat_take ? in_word.sat_rem - rhs_pkg::SatRemW'(in_word.sat_div)
                                  : in_word.sat_rem;
      word_in.hue_div  = in_word.hue_div >> 1;
      word_in.sat_div  = in_word.sat_div >> 1;
      word_in.hue_quot = {in_word.hue_quot[rhs_pkg::QuotW-2:0], hue_take};
      word_in.sat_quot = {in_word.sat_quot[rhs_pkg::QuotW-2:0], sat_take};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/rgb_to_hue_saturation_unit.sv =====
// Top level of the RGB to hue/saturation unit.
//
// req_port takes one 8-bit RGB pixel per word; rsp_port returns one word
// with hue (0..253, a full turn maps to 254) and saturation (0..254).
// A grey pixel gives hue 0 and saturation 0.
// The datapath is a front stage that finds max/min and sets up both
// divisions, followed by a row of 8 identical cells, each resolving one
// quotient bit of both divisions by compare and subtract.
// A word passes the front-stage register and the 8 cell registers before
// rsp valid; one word is accepted every cycle unless the output stalls.
// Every stage holds its own valid bit and takes a new word whenever it is
// empty or its successor takes its word, so bubbles close up and input is
// still accepted while a finished result waits at the output.
// When the receiver stalls, words pile up in the row; once all 9 stages
// are full req ready drops until rsp ready returns.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module rgb_to_hue_saturation_unit (
   input  wire logic clock,
   input  wire logic reset,
   rhs_req_if.sink   req_port,
   rhs_rsp_if.source rsp_port
);

   localparam int Cells = rhs_pkg::QuotW;

   logic                  stage_valid [Cells+1];
   logic                  stage_ready [Cells+1];
   rhs_pkg::div_word_type stage_word  [Cells+1];

   rhs_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .red       (req_port.red),
      .green     (req_port.green),
      .blue      (req_port.blue),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_word  (stage_word[0])
   );

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      rhs_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_word   (stage_word[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_word  (stage_word[i+1])
      );
   end

   assign stage_ready[Cells]  = rsp_port.ready;
   assign rsp_port.valid      = stage_valid[Cells];
   assign rsp_port.hue        = stage_word[Cells].hue_quot;
   assign rsp_port.saturation = stage_word[Cells].sat_quot;

endmodule
`default_nettype wire
